FILE: src/gradient_color_map_assert.svh
// Assertion macros for the gradient color map.
// Used by gradient_color_map.sv; needs a clock and an active-high reset name.
`ifndef GRADIENT_COLOR_MAP_ASSERT_SVH
`define GRADIENT_COLOR_MAP_ASSERT_SVH

// same-cycle implication
`define GCM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gradient_color_map: implication check failed");

// implication after a fixed number of cycles
`define GCM_ASSERT_DLY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ## (dly) (cons)) \
      else $error("gradient_color_map: delayed check failed");

`endif

FILE: src/gcm_pkg.sv
// Shared types and constants for the gradient color map.
// No dependencies; imported by gradient_color_map.
package gcm_pkg;

   localparam int FIELD_W   = 16;
   localparam int WORD_W    = 64;
   localparam int CNT_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int STOP_CAP  = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_0     = 3'd1;

   localparam logic [CNT_W-1:0] STOP_COUNT_RESET = 3'd5;

   localparam logic [WORD_W-1:0] STOP_RESET [STOP_CAP] = '{
      64'h0000_0000_0000_8000,
      64'h2000_0000_8000_8000,
      64'h4000_0000_8000_0000,
      64'h6000_8000_8000_0000,
      64'h8000_8000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000
   };

   typedef struct packed {
      logic               neg;
      logic [FIELD_W-1:0] diff;
      logic [FIELD_W-1:0] curr;
   } chan_type;

endpackage

FILE: src/gradient_color_map.sv
// Gradient color map: level to RGB through up to MAX_STOPS configured stops.
// Path: capture, stop select, divider operands, divider steps, multiply and output registers, in that order.
// Throughput: one request per cycle while busy is low; the FRAC_BITS+1 restoring divider steps set the depth.
// Reset: synchronous, clears all valid bits and restores the default five-stop gradient.
// busy is high only during reset; the receiver cannot stall, so the pipeline never holds.
// Depends on gcm_pkg and gradient_color_map_assert.svh.
`include "gradient_color_map_assert.svh"

module gradient_color_map
   import gcm_pkg::*;
#(
   parameter int MAX_STOPS = 7,
   parameter int FRAC_BITS = 15
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [FIELD_W-1:0]   req_level,
   output logic                 rsp_valid,
   output logic [FIELD_W-1:0]   rsp_out_red,
   output logic [FIELD_W-1:0]   rsp_out_green,
   output logic [FIELD_W-1:0]   rsp_out_blue,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   localparam int FW     = FRAC_BITS + 1;
   localparam int REM_W  = FIELD_W + 1;
   localparam int PROD_W = FIELD_W + FW;
   localparam int LAT    = FRAC_BITS + 6;
   localparam logic [FW-1:0]     F_ONE  = FW'(1) << FRAC_BITS;
   localparam logic [PROD_W:0]   RND    = (PROD_W+1)'(F_ONE) - (PROD_W+1)'(1);
   localparam logic [CNT_W-1:0]  N_MAX  = CNT_W'(MAX_STOPS);

   // configuration
   logic [CNT_W-1:0]  stop_count_ff;
   logic [WORD_W-1:0] stop_ff [MAX_STOPS];

   assign csr_ready = 1'b1;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= STOP_COUNT_RESET;
      end else if (csr_valid && csr_ready && csr_index == CSR_STOP_COUNT) begin
         stop_count_ff <= csr_wdata[CNT_W-1:0];
      end
   end

   for (genvar g = 0; g < MAX_STOPS; g++) begin : g_stop
      always_ff @(posedge clock) begin
         if (reset) begin
            stop_ff[g] <= STOP_RESET[g];
         end else if (csr_valid && csr_ready &&
                      csr_index == CSR_IDX_W'(CSR_STOP_0 + CSR_IDX_W'(g))) begin
            stop_ff[g] <= csr_wdata;
         end
      end
   end

   // stage 1: capture request
   logic               s1_valid_ff;
   logic [FIELD_W-1:0] s1_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_level_ff <= req_level;
   end

   // stage 2: compare against stops, pick current and previous stop
   logic [CNT_W-1:0]     n_eff;
   logic [MAX_STOPS-1:0] lt_vec;
   logic [MAX_STOPS-1:0] first_oh;
   logic [MAX_STOPS-1:0] last_oh;
   logic [MAX_STOPS-1:0] c_oh_in;
   logic [MAX_STOPS-1:0] p_oh_in;
   logic                 found_in;

   always_comb begin
      if (stop_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (stop_count_ff > N_MAX) begin
         n_eff = N_MAX;
      end else begin
         n_eff = stop_count_ff;
      end
      for (int i = 0; i < MAX_STOPS; i++) begin
         lt_vec[i]  = (CNT_W'(i) < n_eff) && (s1_level_ff < stop_ff[i][63:48]);
         last_oh[i] = (n_eff == CNT_W'(i + 1));
      end
      first_oh = lt_vec & (~lt_vec + MAX_STOPS'(1));
      found_in = |lt_vec;
      if (!found_in) begin
         c_oh_in = last_oh;
         p_oh_in = last_oh;
      end else if (first_oh[0]) begin
         c_oh_in = first_oh;
         p_oh_in = first_oh;
      end else begin
         c_oh_in = first_oh;
         p_oh_in = first_oh >> 1;
      end
   end

   logic                 s2_valid_ff;
   logic                 s2_found_ff;
   logic [FIELD_W-1:0]   s2_level_ff;
   logic [MAX_STOPS-1:0] s2_c_oh_ff;
   logic [MAX_STOPS-1:0] s2_p_oh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_found_ff <= found_in;
      s2_level_ff <= s1_level_ff;
      s2_c_oh_ff  <= c_oh_in;
      s2_p_oh_ff  <= p_oh_in;
   end

   // stage 3 and divider: index 0 holds operands, each later index one quotient bit
   logic                dv_valid_ff [FW+1];
   logic                dv_gt_ff    [FW+1];
   logic [REM_W-1:0]    dv_rem_ff   [FW+1];
   logic [FIELD_W-1:0]  dv_div_ff   [FW+1];
   logic [FW-1:0]       dv_quo_ff   [FW+1];
   chan_type [2:0]      dv_chan_ff  [FW+1];

   logic [WORD_W-1:0]  cw;
   logic [WORD_W-1:0]  pw;
   logic [FIELD_W-1:0] cpos;
   logic [FIELD_W-1:0] ppos;
   chan_type [2:0]     chan_in;

   always_comb begin
      cw = '0;
      pw = '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
         cw = cw | ({WORD_W{s2_c_oh_ff[i]}} & stop_ff[i]);
         pw = pw | ({WORD_W{s2_p_oh_ff[i]}} & stop_ff[i]);
      end
      cpos = cw[63:48];
      ppos = pw[63:48];
      for (int c = 0; c < 3; c++) begin
         chan_in[c].curr = cw[c*FIELD_W +: FIELD_W];
         chan_in[c].neg  = pw[c*FIELD_W +: FIELD_W] < cw[c*FIELD_W +: FIELD_W];
         chan_in[c].diff = chan_in[c].neg ?
                           cw[c*FIELD_W +: FIELD_W] - pw[c*FIELD_W +: FIELD_W] :
                           pw[c*FIELD_W +: FIELD_W] - cw[c*FIELD_W +: FIELD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dv_gt_ff[0]   <= s2_found_ff && (cpos > ppos);
      dv_rem_ff[0]  <= {1'b0, cpos - s2_level_ff};
      dv_div_ff[0]  <= cpos - ppos;
      dv_quo_ff[0]  <= '0;
      dv_chan_ff[0] <= chan_in;
   end

   for (genvar k = 1; k <= FW; k++) begin : g_div
      logic             qbit;
      logic [REM_W-1:0] nrem;

      always_comb begin
         qbit = dv_rem_ff[k-1] >= {1'b0, dv_div_ff[k-1]};
         nrem = qbit ? dv_rem_ff[k-1] - {1'b0, dv_div_ff[k-1]} : dv_rem_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         dv_gt_ff[k]   <= dv_gt_ff[k-1];
         dv_rem_ff[k]  <= {nrem[FIELD_W-1:0], 1'b0};
         dv_div_ff[k]  <= dv_div_ff[k-1];
         dv_quo_ff[k]  <= {dv_quo_ff[k-1][FW-2:0], qbit};
         dv_chan_ff[k] <= dv_chan_ff[k-1];
      end
   end

   // multiply stage
   logic [FW-1:0]     frac;
   logic              m_valid_ff;
   logic [PROD_W-1:0] m_prod_ff [3];
   chan_type [2:0]    m_chan_ff;

   always_comb begin
      if (!dv_gt_ff[FW]) begin
         frac = '0;
      end else if (dv_quo_ff[FW] > F_ONE) begin
         frac = F_ONE;
      end else begin
         frac = dv_quo_ff[FW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= dv_valid_ff[FW];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         m_prod_ff[c] <= PROD_W'(dv_chan_ff[FW][c].diff) * PROD_W'(frac);
      end
      m_chan_ff <= dv_chan_ff[FW];
   end

   // output stage: floor shift, ceiling on the falling side
   logic [FIELD_W-1:0] out_in [3];

   always_comb begin
      logic [PROD_W:0] step_w;
      step_w = '0;
      for (int c = 0; c < 3; c++) begin
         if (m_chan_ff[c].neg) begin
            step_w    = ({1'b0, m_prod_ff[c]} + RND) >> FRAC_BITS;
            out_in[c] = m_chan_ff[c].curr - step_w[FIELD_W-1:0];
         end else begin
            step_w    = {1'b0, m_prod_ff[c]} >> FRAC_BITS;
            out_in[c] = m_chan_ff[c].curr + step_w[FIELD_W-1:0];
         end
      end
   end

   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_red_ff;
   logic [FIELD_W-1:0] rsp_green_ff;
   logic [FIELD_W-1:0] rsp_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_red_ff   <= out_in[2];
      rsp_green_ff <= out_in[1];
      rsp_blue_ff  <= out_in[0];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;

   `GCM_ASSERT_DLY(a_req_to_rsp, clock, reset, start && !busy, LAT, rsp_valid)
   `GCM_ASSERT_IMP(a_rsp_from_req, clock, reset, rsp_valid, $past(start && !busy, LAT))
   `GCM_ASSERT_IMP(a_frac_bound, clock, reset, dv_valid_ff[FW] && dv_gt_ff[FW], dv_quo_ff[FW] <= F_ONE)

endmodule

FILE: tb/gradient_color_map_test.sv
// Self-checking testbench for gradient_color_map: directed and random levels through
// several gradients, each result compared with an internal gradient predictor.
// Depends on gcm_pkg and the gradient_color_map RTL.
module gradient_color_map_test
   import gcm_pkg::*;
();

   localparam int FRAC        = 15;
   localparam int LATENCY     = FRAC + 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 13;
   localparam int PHASE_ITEMS = 100;

   typedef struct packed {
      logic [FIELD_W-1:0] red;
      logic [FIELD_W-1:0] green;
      logic [FIELD_W-1:0] blue;
   } color_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FIELD_W-1:0]   req_level = '0;
   logic                 rsp_valid;
   logic [FIELD_W-1:0]   rsp_out_red;
   logic [FIELD_W-1:0]   rsp_out_green;
   logic [FIELD_W-1:0]   rsp_out_blue;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   logic [WORD_W-1:0] stop_word_cfg [STOP_CAP];
   logic [CNT_W-1:0]  stop_count_cfg;
   color_type         color_queue [$];
   int                errors = 0;
   int                cycles = 0;

   gradient_color_map uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_level     (req_level),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[gradient_color_map] ERROR");
         $finish;
      end
   end

   function automatic logic [FIELD_W-1:0] lerp_channel(input logic [FIELD_W-1:0] prev,
                                                      input logic [FIELD_W-1:0] curr,
                                                      input logic [31:0] frac);
      logic [31:0] prod;
      logic [31:0] step;
      if (prev >= curr) begin
         prod = 32'(prev - curr) * frac;
         return curr + prod[FIELD_W+FRAC-1:FRAC];
      end
      prod = 32'(curr - prev) * frac;
      step = (prod + (32'd1 << FRAC) - 32'd1) >> FRAC;
      return curr - step[FIELD_W-1:0];
   endfunction

   function automatic color_type map_level(input logic [FIELD_W-1:0] level);
      int                 n;
      int                 hit;
      logic [WORD_W-1:0]  cw;
      logic [WORD_W-1:0]  pw;
      logic [FIELD_W-1:0] cpos;
      logic [FIELD_W-1:0] ppos;
      logic [31:0]        frac;
      color_type          c;
      n = (stop_count_cfg == 0) ? 1 : int'(stop_count_cfg);
      if (n > STOP_CAP) n = STOP_CAP;
      hit = -1;
      for (int i = 0; i < n; i++)
         if (hit < 0 && level < stop_word_cfg[i][63:48]) hit = i;
      if (hit < 0) begin
         cw = stop_word_cfg[n-1];
         c = '{red: cw[47:32], green: cw[31:16], blue: cw[15:0]};
         return c;
      end
      cw = stop_word_cfg[hit];
      pw = stop_word_cfg[(hit == 0) ? 0 : hit - 1];
      cpos = cw[63:48];
      ppos = pw[63:48];
      frac = 0;
      if (cpos > ppos) begin
         frac = (32'(cpos - level) << FRAC) / 32'(cpos - ppos);
         if (frac > (32'd1 << FRAC)) frac = 32'd1 << FRAC;
      end
      c.red   = lerp_channel(pw[47:32], cw[47:32], frac);
      c.green = lerp_channel(pw[31:16], cw[31:16], frac);
      c.blue  = lerp_channel(pw[15:0], cw[15:0], frac);
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, msg);
   endtask

   always @(posedge clock) begin
      color_type want;
      if (!reset && rsp_valid) begin
         if (color_queue.size() == 0) begin
            report_mismatch($sformatf("result %h/%h/%h with no request pending",
                                      rsp_out_red, rsp_out_green, rsp_out_blue));
         end else begin
            want = color_queue.pop_front();
            if (rsp_out_red !== want.red)
               report_mismatch($sformatf("red %h, want %h", rsp_out_red, want.red));
            if (rsp_out_green !== want.green)
               report_mismatch($sformatf("green %h, want %h", rsp_out_green, want.green));
            if (rsp_out_blue !== want.blue)
               report_mismatch($sformatf("blue %h, want %h", rsp_out_blue, want.blue));
         end
      end
   end

   task automatic send_level(input logic [FIELD_W-1:0] level, input int gap_max);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_level <= level;
      @(posedge clock);
      while (busy) @(posedge clock);
      color_queue.insert(color_queue.size(), map_level(level));
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      @(posedge clock);
      while (color_queue.size() != 0) @(posedge clock);
   endtask

   // hold csr_valid; caller drops it after the last write of a group
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_STOP_COUNT) stop_count_cfg = data[CNT_W-1:0];
      else stop_word_cfg[index - CSR_STOP_0] = data;
   endtask

   task automatic load_gradient(input logic [WORD_W-1:0] count_word,
                                input logic [WORD_W-1:0] words [STOP_CAP]);
      write_reg(CSR_STOP_COUNT, count_word);
      for (int k = 0; k < STOP_CAP; k++)
         write_reg(CSR_IDX_W'(CSR_STOP_0 + k), words[k]);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [FIELD_W-1:0] pick_channel();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return FIELD_W'($urandom);
   endfunction

   function automatic logic [FIELD_W-1:0] pick_level();
      int                 n;
      int                 r;
      logic [FIELD_W-1:0] pos;
      n = (stop_count_cfg == 0) ? 1 : int'(stop_count_cfg);
      pos = stop_word_cfg[$urandom_range(0, n - 1)][63:48];
      r = $urandom_range(0, 9);
      if (r < 5) return FIELD_W'($urandom);
      if (r < 8) return pos + FIELD_W'($urandom_range(0, 4)) - 16'd2;
      if (r == 8) return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      return pos - 16'd1;
   endfunction

   task automatic random_gradient(input bit sorted);
      logic [WORD_W-1:0] words [STOP_CAP];
      logic [WORD_W-1:0] count_word;
      int                pos;
      int                step;
      pos = $urandom_range(0, 16'h2000);
      for (int k = 0; k < STOP_CAP; k++) begin
         if (sorted)
            words[k] = {FIELD_W'(pos), pick_channel(), pick_channel(), pick_channel()};
         else
            words[k] = {$urandom, $urandom};
         step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16'h4000);
         pos = (pos + step > 16'hFFFF) ? 16'hFFFF : pos + step;
      end
      count_word = {$urandom, $urandom};
      count_word[CNT_W-1:0] = CNT_W'($urandom_range(0, 7));
      load_gradient(count_word, words);
   endtask

   task automatic test_default_gradient();
      logic [FIELD_W-1:0] levels [] = '{16'h0000, 16'h0001, 16'h1FFF, 16'h2000, 16'h2001,
                                        16'h3000, 16'h4000, 16'h5555, 16'h7FFF, 16'h8000,
                                        16'hFFFF};
      foreach (levels[k]) send_level(levels[k], (k % 2) ? 0 : 12);
   endtask

   task automatic test_corner_gradients();
      logic [WORD_W-1:0]  words [STOP_CAP] = '{
         {16'h1000, 16'hFFFF, 16'h0000, 16'h8000},
         {16'h4000, 16'h0000, 16'hFFFF, 16'h0001},
         {16'h4000, 16'h1234, 16'h8000, 16'hFFFF},
         {16'h3000, 16'hFFFF, 16'hFFFF, 16'h0000},
         {16'h9000, 16'h0000, 16'h0000, 16'h0000},
         {16'hC000, 16'hABCD, 16'h5432, 16'hFFFF},
         {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}
      };
      logic [FIELD_W-1:0] levels [] = '{16'h0000, 16'h0FFF, 16'h1000, 16'h3800, 16'h4000,
                                        16'h8FFF, 16'hBFFF, 16'hFFFE, 16'hFFFF};
      wait_drain();
      write_reg(CSR_STOP_COUNT, 64'hFFFF_FFFF_FFFF_FFF8);
      write_reg(CSR_STOP_0, '1);
      csr_valid <= 1'b0;
      send_level(16'h0000, 12);
      send_level(16'hFFFF, 0);
      wait_drain();
      load_gradient(64'd7, words);
      foreach (levels[k]) send_level(levels[k], (k % 3) ? 0 : 12);
   endtask

   task automatic test_random_gradients();
      logic [WORD_W-1:0] ones [STOP_CAP] = '{default: '1};
      logic [WORD_W-1:0] zeros [STOP_CAP] = '{default: '0};
      bit                burst;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drain();
         burst = (phase % 4 == 3);
         if (phase == 0) load_gradient(64'd7, ones);
         else if (phase == 1) load_gradient(64'd7, zeros);
         else random_gradient($urandom_range(0, 4) != 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2 && phase % 3 == 2) wait_drain();
            send_level(pick_level(), burst ? 0 : 12);
         end
      end
   endtask

   initial begin
      stop_word_cfg = STOP_RESET;
      stop_count_cfg = STOP_COUNT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_gradient();
      test_corner_gradients();
      test_random_gradients();
      wait_drain();
      repeat (LATENCY + 4) @(posedge clock);
      if (errors == 0)
         $display("[gradient_color_map] OK");
      else
         $display("[gradient_color_map] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/gcm_pkg.sv
src/gradient_color_map.sv
tb/gradient_color_map_test.sv
